>>> design/serial_frame_receiver_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the serial frame receiver
// Same-cycle and next-cycle implication checks under synchronous reset.
// ---------------------------------------------------------------------------
`ifndef SERIAL_FRAME_RECEIVER_CORE_ASSERT_SVH
`define SERIAL_FRAME_RECEIVER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SFR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SFR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/sfr_pkg.sv
// ---------------------------------------------------------------------------
// sfr_pkg
// Types and constants shared by the serial frame receiver modules.
// ---------------------------------------------------------------------------
package sfr_pkg;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned LIMIT_W    = 9;
   localparam int unsigned KIND_W     = 2;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 9;

   localparam logic [CSR_IDX_W-1:0] CSR_HEAD_FIRST  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEAD_SECOND = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ID_LIMIT    = 2'd2;

   localparam logic [BYTE_W-1:0]  HEAD_FIRST_RST  = 8'hA5;
   localparam logic [BYTE_W-1:0]  HEAD_SECOND_RST = 8'h5A;
   localparam logic [LIMIT_W-1:0] ID_LIMIT_RST    = 9'd16;

   typedef enum logic [KIND_W-1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_GOOD    = 2'd1,
      KIND_BAD     = 2'd2
   } kind_type;

   typedef enum logic [5:0] {
      PH_HEAD1 = 6'b000001,
      PH_HEAD2 = 6'b000010,
      PH_ID    = 6'b000100,
      PH_LEN   = 6'b001000,
      PH_DATA  = 6'b010000,
      PH_CHECK = 6'b100000
   } phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  head_first;
      logic [BYTE_W-1:0]  head_second;
      logic [LIMIT_W-1:0] id_limit;
   } cfg_type;

   typedef struct packed {
      kind_type          kind;
      logic [BYTE_W-1:0] msg_id;
      logic [BYTE_W-1:0] data_byte;
      logic [BYTE_W-1:0] byte_index;
      logic [BYTE_W-1:0] frame_length;
   } result_type;

endpackage

>>> design/sfr_ifs.sv
// ---------------------------------------------------------------------------
// Serial frame receiver channels
// Request, response and register-write valid/ready interfaces.
// ---------------------------------------------------------------------------
interface sfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfr_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] msg_id;
   logic [7:0] data_byte;
   logic [7:0] byte_index;
   logic [7:0] frame_length;

   modport source (output valid, output kind, output msg_id, output data_byte,
                   output byte_index, output frame_length, input ready);
   modport sink   (input valid, input kind, input msg_id, input data_byte,
                   input byte_index, input frame_length, output ready);
endinterface

interface sfr_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [8:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/sfr_csr_regs.sv
// ---------------------------------------------------------------------------
// sfr_csr_regs
// Header and id limit registers, written through the register channel.
// ---------------------------------------------------------------------------
module sfr_csr_regs (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             wr_en,
   input  logic [sfr_pkg::CSR_IDX_W-1:0]    wr_index,
   input  logic [sfr_pkg::CSR_DATA_W-1:0]   wr_data,
   output sfr_pkg::cfg_type                 cfg
);
   import sfr_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            CSR_HEAD_FIRST:  cfg_in.head_first  = wr_data[BYTE_W-1:0];
            CSR_HEAD_SECOND: cfg_in.head_second = wr_data[BYTE_W-1:0];
            CSR_ID_LIMIT:    cfg_in.id_limit    = wr_data[LIMIT_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.head_first  <= HEAD_FIRST_RST;
         cfg_ff.head_second <= HEAD_SECOND_RST;
         cfg_ff.id_limit    <= ID_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> design/sfr_parser.sv
// ---------------------------------------------------------------------------
// sfr_parser
// Frame state machine: header hunt, id and length capture, running sum.
// ---------------------------------------------------------------------------
module sfr_parser (
   input  logic                        clock,
   input  logic                        reset,
   input  sfr_pkg::cfg_type            cfg,
   input  logic                        in_fire,
   input  logic [sfr_pkg::BYTE_W-1:0]  rx_byte,
   output sfr_pkg::phase_type          phase,
   output logic                        res_valid,
   output sfr_pkg::result_type         res
);
   import sfr_pkg::*;

   phase_type         phase_ff,  phase_in;
   logic [BYTE_W-1:0] id_ff,     id_in;
   logic [BYTE_W-1:0] len_ff,    len_in;
   logic [BYTE_W-1:0] count_ff,  count_in;
   logic [BYTE_W-1:0] sum_ff,    sum_in;
   logic [BYTE_W-1:0] sum_add;

   assign sum_add = sum_ff + rx_byte;

   always_comb begin
      phase_in  = phase_ff;
      id_in     = id_ff;
      len_in    = len_ff;
      count_in  = count_ff;
      sum_in    = sum_ff;
      res_valid = 1'b0;
      res.kind         = KIND_PAYLOAD;
      res.msg_id       = id_ff;
      res.data_byte    = rx_byte;
      res.byte_index   = count_ff;
      res.frame_length = len_ff;
      if (in_fire) begin
         unique case (phase_ff)
            PH_HEAD2: begin
               if (rx_byte == cfg.head_second) begin
                  sum_in   = sum_add;
                  phase_in = PH_ID;
               end else begin
                  phase_in = PH_HEAD1;
               end
            end
            PH_ID: begin
               if ({1'b0, rx_byte} < cfg.id_limit) begin
                  id_in    = rx_byte;
                  sum_in   = sum_add;
                  phase_in = PH_LEN;
               end else begin
                  phase_in = PH_HEAD1;
               end
            end
            PH_LEN: begin
               len_in   = rx_byte;
               sum_in   = sum_add;
               phase_in = (rx_byte == '0) ? PH_CHECK : PH_DATA;
            end
            PH_DATA: begin
               res_valid = 1'b1;
               sum_in    = sum_add;
               count_in  = count_ff + 8'd1;
               // advance to the checksum once the last payload byte is in
               if (count_in >= len_ff) begin
                  phase_in = PH_CHECK;
               end
            end
            PH_CHECK: begin
               res_valid      = 1'b1;
               res.kind       = (sum_ff == rx_byte) ? KIND_GOOD : KIND_BAD;
               res.byte_index = '0;
               phase_in       = PH_HEAD1;
            end
            default: begin
               phase_in = PH_HEAD1;
               if (rx_byte == cfg.head_first) begin
                  id_in    = '0;
                  len_in   = '0;
                  count_in = '0;
                  sum_in   = rx_byte;
                  phase_in = PH_HEAD2;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEAD1;
         id_ff    <= '0;
         len_ff   <= '0;
         count_ff <= '0;
         sum_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         id_ff    <= id_in;
         len_ff   <= len_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
      end
   end

   assign phase = phase_ff;

endmodule

>>> design/sfr_out_stage.sv
// ---------------------------------------------------------------------------
// sfr_out_stage
// Response register; takes a new result whenever empty or being drained.
// ---------------------------------------------------------------------------
module sfr_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load_en,
   input  sfr_pkg::result_type  load_data,
   output logic                 can_load,
   output logic                 out_valid,
   input  logic                 out_ready,
   output sfr_pkg::result_type  out_data
);
   import sfr_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff,  data_in;

   assign can_load = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (can_load) begin
         valid_in = load_en;
      end
      if (load_en) begin
         data_in = load_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> design/serial_frame_receiver_core.sv
// ---------------------------------------------------------------------------
// serial_frame_receiver_core
// Byte-serial frame parser: header pair, id, length, payload, 8-bit sum check.
// ---------------------------------------------------------------------------
//  channel   dir  payload                                          when
//  req_if    in   rx_byte                                          valid && ready
//  rsp_if    out  kind, msg_id, data_byte, byte_index, frame_length valid && ready
//  csr_if    in   index, data                                      valid (ready high)
//
//  One byte per cycle while the response register can load; a result sits in
//  the response register in the cycle after its byte is taken.
//  Synchronous reset returns to the first header hunt with default registers.
//  A stalled response holds req_if.ready low only while the register is full.
// ---------------------------------------------------------------------------
module serial_frame_receiver_core (
   input  logic      clock,
   input  logic      reset,
   sfr_req_if.sink   req_if,
   sfr_rsp_if.source rsp_if,
   sfr_csr_if.sink   csr_if
);
   import sfr_pkg::*;

   `include "serial_frame_receiver_core_assert.svh"

   cfg_type    cfg;
   phase_type  phase;
   logic       in_fire;
   logic       can_load;
   logic       res_valid;
   result_type res;
   result_type out_data;

   assign csr_if.ready = 1'b1;
   assign req_if.ready = can_load;
   assign in_fire      = req_if.valid && can_load;

   sfr_csr_regs u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_if.valid),
      .wr_index (csr_if.index),
      .wr_data  (csr_if.data),
      .cfg      (cfg)
   );

   sfr_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_fire   (in_fire),
      .rx_byte   (req_if.rx_byte),
      .phase     (phase),
      .res_valid (res_valid),
      .res       (res)
   );

   sfr_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load_en   (res_valid),
      .load_data (res),
      .can_load  (can_load),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .out_data  (out_data)
   );

   assign rsp_if.kind         = out_data.kind;
   assign rsp_if.msg_id       = out_data.msg_id;
   assign rsp_if.data_byte    = out_data.data_byte;
   assign rsp_if.byte_index   = out_data.byte_index;
   assign rsp_if.frame_length = out_data.frame_length;

   `SFR_ASSERT_NEXT(a_payload_emits, clock, reset,
      in_fire && (phase == PH_DATA || phase == PH_CHECK), rsp_if.valid,
      "payload or checksum request did not produce a response")

   `SFR_ASSERT_NEXT(a_header_silent, clock, reset,
      in_fire && (phase == PH_HEAD1 || phase == PH_HEAD2 ||
                  phase == PH_ID || phase == PH_LEN), !rsp_if.valid,
      "header, id or length request produced a response")

   `SFR_ASSERT_SAME(a_close_index, clock, reset,
      rsp_if.valid && rsp_if.kind != KIND_PAYLOAD, rsp_if.byte_index == '0,
      "closing response carries a nonzero byte index")

endmodule
